// ----- sv/amc_pkg.sv -----
// Shared constants and types for the accelerometer motion conditioner.
// No dependencies; the controller, datapath and top level import it.
package amc_pkg;

   localparam int BASE_FRAC = 8;               // baseline fraction bits
   localparam int BW        = 16 + BASE_FRAC;  // magnitude / baseline width
   localparam int DW        = 15 + BASE_FRAC;  // level divisor width

   localparam logic [15:0] GAIN_RISE = 16'd39322;  // 0.6 in Q0.16
   localparam logic [15:0] GAIN_FALL = 16'd9830;   // 0.15 in Q0.16

   localparam int ROOT_STEPS = 16;
   localparam int DIV_STEPS  = 16;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_RANGE    = 3'd0;
   localparam csr_index_type CSR_ACTIVITY = 3'd1;
   localparam csr_index_type CSR_ALPHA    = 3'd2;
   localparam csr_index_type CSR_MAX_AGE  = 3'd3;
   localparam csr_index_type CSR_AXIS_MAP = 3'd4;
   localparam csr_index_type CSR_AXIS_SGN = 3'd5;
   localparam csr_index_type CSR_BOOT_ID  = 3'd6;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_IDLE  = 2'd0;
   localparam kind_type KIND_SENT  = 2'd1;
   localparam kind_type KIND_STALE = 2'd2;
   localparam kind_type KIND_BUSY  = 2'd3;

   typedef struct packed {
      logic       load;
      logic       square;
      logic [1:0] sq_sel;
      logic       root;
      logic       base;
      logic       div;
      logic       act;
   } amc_cmd_type;

endpackage

// ----- sv/amc_ctrl.sv -----
// Sequencer for the motion conditioner: walks one item through load,
// squares, root, baseline, level divide and activity. Uses amc_pkg.
module amc_ctrl import amc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output amc_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SQ   = 7'b0000010,
      ST_ROOT = 7'b0000100,
      ST_BASE = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_ACT  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SQ;
               cnt_in   = '0;
            end
         end
         ST_SQ: begin
            cmd.square = 1'b1;
            cmd.sq_sel = cnt_ff[1:0];
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) begin
               state_in = ST_ROOT;
               cnt_in   = '0;
            end
         end
         ST_ROOT: begin
            cmd.root = 1'b1;
            cnt_in   = cnt_ff + 4'd1;
            if (cnt_ff == 4'(ROOT_STEPS - 1)) state_in = ST_BASE;
         end
         ST_BASE: begin
            cmd.base = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'(DIV_STEPS - 1)) state_in = ST_ACT;
         end
         ST_ACT: begin
            cmd.act  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- sv/amc_datapath.sv -----
// Datapath of the motion conditioner: config registers, axis remap and
// clamp, shared square/root/divide steps, baseline, activity and stream state.
// Driven by amc_ctrl commands; uses amc_pkg.
module amc_datapath import amc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  amc_cmd_type        cmd,
   input  logic               csr_we,
   input  csr_index_type      csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic signed [15:0] raw_x,
   input  logic signed [15:0] raw_y,
   input  logic signed [15:0] raw_z,
   input  logic               sensor_saturated,
   input  logic [31:0]        capture_time,
   input  logic [31:0]        current_time,
   input  logic [31:0]        stream_generation,
   input  logic               recalibrate,
   input  logic               gap_seen,
   input  logic               link_accepts,
   output logic signed [15:0] out_x,
   output logic signed [15:0] out_y,
   output logic signed [15:0] out_z,
   output logic               flag_saturated,
   output logic               flag_discontinuity,
   output logic [15:0]        seq_number,
   output logic [31:0]        capture_out,
   output logic [15:0]        activity_level,
   output kind_type           record_kind
);

   // configuration
   logic [14:0] range_ff;
   logic [13:0] act_mg_ff;
   logic [15:0] alpha_ff;
   logic [15:0] max_age_ff;
   logic [5:0]  axis_map_ff;
   logic [2:0]  axis_sign_ff;
   logic        reseed_ff;

   // state
   logic [BW-1:0] baseline_ff;
   logic          ready_ff;
   logic [15:0]   activity_ff;
   logic [15:0]   seq_ff;
   logic          disc_ff;
   logic [31:0]   seen_gen_ff;

   // per item payload
   logic signed [15:0] v_ff [3];
   logic        sat_ff, recal_ff, gap_ff, link_ff;
   logic [31:0] cap_ff, now_ff, gen_ff;
   logic [31:0] n_ff, res_ff, bit_ff;
   logic [DW-1:0] rem_ff;
   logic [15:0] q_ff;
   logic        over_ff, zero_ff;
   logic        flag_disc_ff;
   kind_type    kind_ff;

   // remap and clamp
   logic signed [15:0] chip [3];
   logic signed [15:0] v_in [3];
   logic               clamp_sat;

   always_comb begin
      logic [1:0]         sel;
      logic signed [16:0] a;
      logic signed [16:0] lim;
      chip[0]   = raw_x;
      chip[1]   = raw_y;
      chip[2]   = raw_z;
      clamp_sat = 1'b0;
      lim       = $signed({2'b00, range_ff});
      for (int i = 0; i < 3; i++) begin
         sel = axis_map_ff[2*i +: 2];
         a   = (sel == 2'd3) ? 17'(chip[i]) : 17'(chip[sel]);
         if (axis_sign_ff[i]) a = -a;
         if (a > lim) begin
            a = lim;
            clamp_sat = 1'b1;
         end
         if (a < -lim) begin
            a = -lim;
            clamp_sat = 1'b1;
         end
         v_in[i] = a[15:0];
      end
   end

   // square accumulate
   logic signed [15:0] sq_op;
   logic signed [31:0] sq_prod;
   always_comb begin
      case (cmd.sq_sel)
         2'd0:    sq_op = v_ff[0];
         2'd1:    sq_op = v_ff[1];
         default: sq_op = v_ff[2];
      endcase
      sq_prod = sq_op * sq_op;
   end

   // one root step
   logic [31:0] root_t;
   assign root_t = res_ff + bit_ff;

   // baseline
   logic [BW-1:0]    magq, base_cur, jolt;
   logic             reseed, mag_ge, gate;
   logic [BW+15:0]   base_prod;
   logic [BW-1:0]    base_step;
   logic [DW-1:0]    divisor;
   always_comb begin
      magq      = {res_ff[15:0], {BASE_FRAC{1'b0}}};
      reseed    = recal_ff | reseed_ff | ~ready_ff;
      base_cur  = reseed ? magq : baseline_ff;
      mag_ge    = (magq >= base_cur);
      jolt      = mag_ge ? magq - base_cur : base_cur - magq;
      gate      = ({jolt, 1'b0} < {2'b00, act_mg_ff, {BASE_FRAC{1'b0}}});
      base_prod = jolt * alpha_ff;
      base_step = base_prod[BW+15:16];
      divisor   = {act_mg_ff, 1'b0, {BASE_FRAC{1'b0}}};
   end

   // one divide step
   logic [DW:0] rem2;
   assign rem2 = {rem_ff, 1'b0};

   // activity and stream decision
   logic [15:0] level, act_diff, act_delta;
   logic [31:0] act_prod, age;
   logic        rise;
   always_comb begin
      if (zero_ff)      level = 16'd0;
      else if (over_ff) level = 16'hFFFF;
      else              level = q_ff;
      rise      = (level > activity_ff);
      act_diff  = rise ? level - activity_ff : activity_ff - level;
      act_prod  = act_diff * (rise ? GAIN_RISE : GAIN_FALL);
      act_delta = act_prod[31:16];
      age       = now_ff - cap_ff;
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff     <= 15'd16000;
         act_mg_ff    <= 14'd200;
         alpha_ff     <= 16'd655;
         max_age_ff   <= 16'd50;
         axis_map_ff  <= 6'd36;
         axis_sign_ff <= 3'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RANGE:    range_ff     <= csr_wdata[14:0];
            CSR_ACTIVITY: act_mg_ff    <= csr_wdata[13:0];
            CSR_ALPHA:    alpha_ff     <= csr_wdata[15:0];
            CSR_MAX_AGE:  max_age_ff   <= csr_wdata[15:0];
            CSR_AXIS_MAP: axis_map_ff  <= csr_wdata[5:0];
            CSR_AXIS_SGN: axis_sign_ff <= csr_wdata[2:0];
            CSR_BOOT_ID:  ;  // record framing is outside this block
            default:      ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reseed_ff   <= 1'b0;
         baseline_ff <= '0;
         ready_ff    <= 1'b0;
         activity_ff <= '0;
         seq_ff      <= 16'hFFFF;
         disc_ff     <= 1'b0;
         seen_gen_ff <= '0;
      end else begin
         if (cmd.load) seq_ff <= seq_ff + 16'd1;
         if (cmd.base) begin
            reseed_ff   <= 1'b0;
            ready_ff    <= 1'b1;
            baseline_ff <= !gate ? base_cur :
                           mag_ge ? base_cur + base_step : base_cur - base_step;
         end
         if (cmd.act) begin
            activity_ff <= rise ? activity_ff + act_delta : activity_ff - act_delta;
            if (gen_ff != seen_gen_ff) seen_gen_ff <= gen_ff;
            if (gen_ff == 32'd0)
               disc_ff <= disc_ff | gap_ff | (gen_ff != seen_gen_ff);
            else if (age > {16'd0, max_age_ff})
               disc_ff <= 1'b1;
            else
               disc_ff <= ~link_ff;
         end
         // axis changes reseed on the next item
         if (csr_we && (csr_index == CSR_AXIS_MAP || csr_index == CSR_AXIS_SGN))
            reseed_ff <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      logic d;
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) v_ff[i] <= v_in[i];
         sat_ff   <= sensor_saturated | clamp_sat;
         cap_ff   <= capture_time;
         now_ff   <= current_time;
         gen_ff   <= stream_generation;
         recal_ff <= recalibrate;
         gap_ff   <= gap_seen;
         link_ff  <= link_accepts;
         n_ff     <= '0;
         res_ff   <= '0;
         bit_ff   <= 32'h4000_0000;
      end
      if (cmd.square) n_ff <= n_ff + $unsigned(sq_prod);
      if (cmd.root) begin
         if (n_ff >= root_t) begin
            n_ff   <= n_ff - root_t;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.base) begin
         zero_ff <= (act_mg_ff == '0) && (jolt == '0);
         over_ff <= (act_mg_ff == '0) || (jolt >= BW'(divisor));
         rem_ff  <= jolt[DW-1:0];
         q_ff    <= '0;
      end
      if (cmd.div) begin
         if (rem2 >= {1'b0, divisor}) begin
            rem_ff <= DW'(rem2 - {1'b0, divisor});
            q_ff   <= {q_ff[14:0], 1'b1};
         end else begin
            rem_ff <= rem2[DW-1:0];
            q_ff   <= {q_ff[14:0], 1'b0};
         end
      end
      if (cmd.act) begin
         d = disc_ff | gap_ff | (gen_ff != seen_gen_ff);
         if (gen_ff == 32'd0) begin
            kind_ff      <= KIND_IDLE;
            flag_disc_ff <= d;
         end else if (age > {16'd0, max_age_ff}) begin
            kind_ff      <= KIND_STALE;
            flag_disc_ff <= 1'b1;
         end else begin
            kind_ff      <= link_ff ? KIND_SENT : KIND_BUSY;
            flag_disc_ff <= d;
         end
      end
   end

   assign out_x              = v_ff[0];
   assign out_y              = v_ff[1];
   assign out_z              = v_ff[2];
   assign flag_saturated     = sat_ff;
   assign flag_discontinuity = flag_disc_ff;
   assign seq_number         = seq_ff;
   assign capture_out        = cap_ff;
   assign activity_level     = activity_ff;
   assign record_kind        = kind_ff;

endmodule

// ----- sv/accel_motion_conditioner.sv -----
// Top level of the accelerometer motion conditioner.
// Joins amc_ctrl and amc_datapath; uses amc_pkg.
//
// One sample item in, one result item out. The load with remap and clamp
// happens in the accepting cycle itself; rsp_tvalid then rises after three
// squares through the shared 16x16 squarer, sixteen steps of the bit-pair
// square root, a baseline update, sixteen restoring divide steps for the
// level and an activity/stream update. A new item is accepted only once the
// previous result has been taken. Configuration is written through
// csr_we/csr_index/csr_wdata; the user must write it only while idle, which
// the block itself does not enforce; writing axis_map or axis_sign reseeds
// the baseline on the next item.
module accel_motion_conditioner import amc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // raw_x, raw_y, raw_z, capture_time, current_time, stream_generation
   input  logic [143:0]  req_tdata,
   // sensor_saturated, recalibrate, gap_seen, link_accepts
   input  logic [3:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // out_x, out_y, out_z, seq_number, capture_out, activity_level
   output logic [111:0]  rsp_tdata,
   // flag_saturated, flag_discontinuity, record_kind
   output logic [3:0]    rsp_tuser,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wdata
);

   amc_cmd_type        cmd;
   logic signed [15:0] out_x, out_y, out_z;
   logic               flag_saturated, flag_discontinuity;
   logic [15:0]        seq_number, activity_level;
   logic [31:0]        capture_out;
   kind_type           record_kind;

   amc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   amc_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .raw_x              (req_tdata[15:0]),
      .raw_y              (req_tdata[31:16]),
      .raw_z              (req_tdata[47:32]),
      .sensor_saturated   (req_tuser[0]),
      .capture_time       (req_tdata[79:48]),
      .current_time       (req_tdata[111:80]),
      .stream_generation  (req_tdata[143:112]),
      .recalibrate        (req_tuser[1]),
      .gap_seen           (req_tuser[2]),
      .link_accepts       (req_tuser[3]),
      .out_x              (out_x),
      .out_y              (out_y),
      .out_z              (out_z),
      .flag_saturated     (flag_saturated),
      .flag_discontinuity (flag_discontinuity),
      .seq_number         (seq_number),
      .capture_out        (capture_out),
      .activity_level     (activity_level),
      .record_kind        (record_kind)
   );

   assign rsp_tdata = {activity_level, capture_out, seq_number, out_z, out_y, out_x};
   assign rsp_tuser = {record_kind, flag_discontinuity, flag_saturated};

endmodule

// ----- tb/tb_accel_motion_conditioner.sv -----
// Self-checking testbench for accel_motion_conditioner.
// Drives sample items against a cycle-free predictor held in a scoreboard class;
// depends only on amc_pkg and the top level of the block.
module tb_accel_motion_conditioner;
   import amc_pkg::*;

   typedef struct {
      logic [15:0] rx, ry, rz;
      bit          sat;
      bit [31:0]   cap, now, gen;
      bit          recal, gap, link;
   } sample_type;

   typedef struct {
      logic [15:0] x, y, z;
      bit          sat, disc;
      bit [15:0]   seq;
      bit [31:0]   cap;
      bit [15:0]   act;
      kind_type    kind;
   } record_type;

   class motion_scoreboard;
      bit [14:0] range_mg;
      bit [13:0] jolt_mg;
      bit [15:0] alpha;
      bit [15:0] max_age;
      bit [5:0]  axis_map;
      bit [2:0]  axis_sign;
      bit [31:0] boot_id;
      longint unsigned baseline;
      bit        base_ready, disc, reseed;
      bit [15:0] activity, seq;
      bit [31:0] seen_gen;
      record_type expected_q[$];
      int        errors;

      function new();
         range_mg = 16000; jolt_mg = 200; alpha = 655; max_age = 50;
         axis_map = 36; axis_sign = 0; boot_id = 0;
         baseline = 0; base_ready = 0; activity = 0; seq = 16'hFFFF;
         disc = 0; seen_gen = 0; reseed = 0; errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [31:0] val);
         case (idx)
            CSR_RANGE:    range_mg = val[14:0];
            CSR_ACTIVITY: jolt_mg = val[13:0];
            CSR_ALPHA:    alpha = val[15:0];
            CSR_MAX_AGE:  max_age = val[15:0];
            CSR_AXIS_MAP: begin axis_map = val[5:0]; reseed = 1; end
            CSR_AXIS_SGN: begin axis_sign = val[2:0]; reseed = 1; end
            CSR_BOOT_ID:  boot_id = val;
            default: ;
         endcase
      endfunction

      function bit [31:0] int_sqrt(bit [31:0] n);
         bit [31:0] res, b;
         res = 0;
         b = 32'h4000_0000;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n = n - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function void note_sample(sample_type s);
         int        chip[3];
         int        a, lim, sel;
         bit        sat;
         bit [31:0] sumsq, mag, lvl;
         longint unsigned magq, jolt, q, stp;
         record_type r;
         chip[0] = $signed(s.rx);
         chip[1] = $signed(s.ry);
         chip[2] = $signed(s.rz);
         sat = s.sat;
         lim = int'(range_mg);
         sumsq = 0;
         if (s.gap) disc = 1;
         for (int i = 0; i < 3; i++) begin
            sel = (axis_map >> (2 * i)) & 3;
            a = chip[(sel == 3) ? i : sel];
            if (axis_sign[i]) a = -a;
            if (a > lim) begin a = lim; sat = 1; end
            if (a < -lim) begin a = -lim; sat = 1; end
            if (i == 0) r.x = a[15:0];
            else if (i == 1) r.y = a[15:0];
            else r.z = a[15:0];
            sumsq = sumsq + 32'(a * a);
         end
         seq = seq + 16'd1;
         mag = int_sqrt(sumsq);
         magq = longint'(mag) << BASE_FRAC;
         if (s.recal || reseed) begin
            base_ready = 0;
            reseed = 0;
         end
         if (!base_ready) begin
            baseline = magq;
            base_ready = 1;
         end
         jolt = (magq >= baseline) ? magq - baseline : baseline - magq;
         // slow baseline only follows while the jolt stays under half the scale
         if (2 * jolt < (longint'(jolt_mg) << BASE_FRAC)) begin
            stp = (jolt * alpha) >> 16;
            if (magq >= baseline) baseline = baseline + stp;
            else baseline = baseline - stp;
         end
         if (jolt_mg == 0) begin
            lvl = (jolt != 0) ? 32'd65535 : 32'd0;
         end else begin
            q = (jolt << 16) / ((longint'(2 * jolt_mg)) << BASE_FRAC);
            lvl = (q > 65535) ? 32'd65535 : q[31:0];
         end
         if (lvl > activity)
            activity = activity + 16'(((longint'(lvl) - activity) * GAIN_RISE) >> 16);
         else
            activity = activity - 16'(((longint'(activity) - lvl) * GAIN_FALL) >> 16);
         if (s.gen != seen_gen) begin
            disc = 1;
            seen_gen = s.gen;
         end
         if (s.gen == 0) begin
            r.kind = KIND_IDLE;
            r.disc = disc;
         end else if (32'(s.now - s.cap) > max_age) begin
            disc = 1;
            r.kind = KIND_STALE;
            r.disc = 1;
         end else begin
            r.disc = disc;
            if (s.link) begin r.kind = KIND_SENT; disc = 0; end
            else begin r.kind = KIND_BUSY; disc = 1; end
         end
         r.sat = sat;
         r.seq = seq;
         r.cap = s.cap;
         r.act = activity;
         expected_q.push_back(r);
      endfunction

      function void cmp(string name, longint unsigned e, longint unsigned g);
         if (e != g) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, g);
            errors++;
         end
      endfunction

      function void check_record(logic [111:0] d, logic [3:0] u);
         record_type e;
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result item: expected none actual %0h/%0h",
                     $time, d, u);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         cmp("out_x", e.x, d[15:0]);
         cmp("out_y", e.y, d[31:16]);
         cmp("out_z", e.z, d[47:32]);
         cmp("seq_number", e.seq, d[63:48]);
         cmp("capture_out", e.cap, d[95:64]);
         cmp("activity_level", e.act, d[111:96]);
         cmp("flag_saturated", e.sat, u[0]);
         cmp("flag_discontinuity", e.disc, u[1]);
         cmp("record_kind", e.kind, u[3:2]);
      endfunction
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [143:0]  req_tdata = '0;
   logic [3:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [111:0]  rsp_tdata;
   logic [3:0]    rsp_tuser;
   logic          csr_we = 0;
   csr_index_type csr_index = CSR_RANGE;
   logic [31:0]   csr_wdata = '0;

   motion_scoreboard sb = new();
   bit        calm = 0;
   bit        hold_ask = 0;
   bit [31:0] cur_gen = 1;

   accel_motion_conditioner u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // result side: random back-pressure plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            hold_left = 400;
            hold_ask = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 0;
         end else begin
            rsp_tready = calm || ($urandom_range(0, 99) >= 29);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_record(rsp_tdata, rsp_tuser);

   task automatic write_csr(csr_index_type idx, bit [31:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic program_regs(bit [31:0] rng, bit [31:0] act, bit [31:0] alp,
                               bit [31:0] age, bit [31:0] map, bit [31:0] sgn,
                               bit [31:0] boot);
      write_csr(CSR_RANGE, rng);
      write_csr(CSR_ACTIVITY, act);
      write_csr(CSR_ALPHA, alp);
      write_csr(CSR_MAX_AGE, age);
      write_csr(CSR_AXIS_MAP, map);
      write_csr(CSR_AXIS_SGN, sgn);
      write_csr(CSR_BOOT_ID, boot);
   endtask

   task automatic send_sample(sample_type s);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 29) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = {s.gen, s.now, s.cap, s.rz, s.ry, s.rx};
      req_tuser = {s.link, s.gap, s.recal, s.sat};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(s);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic sample_type mk(int x, int y, int z, bit sat, bit [31:0] cap,
                                     bit [31:0] age, bit [31:0] gen, bit recal,
                                     bit gap, bit link);
      sample_type s;
      s.rx = x[15:0]; s.ry = y[15:0]; s.rz = z[15:0];
      s.sat = sat; s.cap = cap; s.now = cap + age; s.gen = gen;
      s.recal = recal; s.gap = gap; s.link = link;
      return s;
   endfunction

   function automatic logic [15:0] rand_axis();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      if (r < 40) return 16'($urandom);
      // near-still sensor so the baseline gate and slow average get exercised
      return 16'(int'($urandom_range(0, 1200)) - 200 + int'($urandom_range(0, 40)) - 20);
   endfunction

   function automatic sample_type rand_sample();
      sample_type s;
      int r;
      s.rx = rand_axis(); s.ry = rand_axis(); s.rz = rand_axis();
      s.sat = ($urandom_range(0, 99) < 5);
      r = $urandom_range(0, 99);
      if (r < 3) cur_gen = 0;
      else if (r < 8 || cur_gen == 0) cur_gen = $urandom;
      s.gen = cur_gen;
      s.cap = $urandom;
      r = $urandom_range(0, 99);
      if (r < 8) s.now = $urandom;
      else if (r < 14) s.now = s.cap + sb.max_age + $urandom_range(0, 3);
      else s.now = s.cap + $urandom_range(0, sb.max_age);
      s.recal = ($urandom_range(0, 99) < 4);
      s.gap = ($urandom_range(0, 99) < 5);
      s.link = ($urandom_range(0, 99) < 80);
      return s;
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed part under reset values, written explicitly
      program_regs(16000, 200, 655, 50, 36, 0, 32'hFFFF_FFFF);
      send_sample(mk(0, 0, 1000, 0, 100, 0, 0, 0, 0, 1));          // not streaming
      send_sample(mk(0, 0, 1000, 0, 200, 10, 5, 0, 0, 1));         // new generation
      send_sample(mk(0, 0, 1000, 0, 300, 50, 5, 0, 0, 1));         // age at limit
      send_sample(mk(0, 0, 1000, 0, 400, 51, 5, 0, 0, 1));         // stale
      send_sample(mk(0, 0, 1000, 0, 500, 0, 5, 0, 0, 0));          // link refused
      send_sample(mk(0, 0, 1000, 0, 600, 0, 5, 0, 0, 1));
      send_sample(mk(0, 0, 1000, 0, 700, 0, 5, 0, 1, 1));          // gap
      send_sample(mk(32767, -32768, 32767, 0, 800, 0, 5, 0, 0, 1)); // clamp
      send_sample(mk(-32768, 32767, -32768, 1, 900, 0, 5, 0, 0, 1));
      send_sample(mk(30, -40, 1010, 0, 1000, 0, 5, 1, 0, 1));      // recalibrate
      send_sample(mk(35, -45, 1020, 0, 1100, 0, 5, 0, 0, 1));
      send_sample(mk(0, 0, 0, 1, 32'hFFFF_FFF0, 32'h20, 5, 0, 0, 1)); // time wrap
      send_sample(mk(0, 0, 1000, 0, 5, 0, 9, 0, 0, 0));
      send_sample(mk(0, 0, 1000, 0, 5, 0, 0, 0, 0, 1));
      wait_drained();
      program_regs(32000, 16383, 65535, 65535, 63, 7, 32'hA5A5_5A5A);
      send_sample(mk(-32768, -32768, -32768, 0, 0, 65535, 3, 0, 0, 1));
      send_sample(mk(32767, 100, -5, 0, 0, 65536, 3, 0, 0, 1));
      send_sample(mk(120, 7, 20000, 0, 0, 32'hFFFF_FFFF, 3, 0, 0, 1));
      wait_drained();
      program_regs(1000, 0, 0, 0, 0, 5, 0);                        // zero scale
      send_sample(mk(500, 2000, -3000, 0, 42, 0, 3, 0, 0, 1));
      send_sample(mk(500, 2000, -3000, 0, 42, 0, 3, 0, 0, 1));
      send_sample(mk(900, -1, 0, 0, 42, 1, 3, 0, 0, 1));
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: program_regs(16000, 200, 655, 50, 36, 0, $urandom);
            1: program_regs(32000, 16383, 65535, 65535, 6'h1B, 3'b010, $urandom);
            2: program_regs(1000, 1, 0, 0, 0, 7, 32'hFFFF_FFFF);
            3: program_regs($urandom_range(1000, 32000), $urandom_range(1, 16383),
                            $urandom_range(0, 65535), $urandom_range(0, 200),
                            $urandom_range(0, 63), $urandom_range(0, 7), $urandom);
            4: program_regs(8000, 2000, 30000, 100, 6'h2D, 3'b101, $urandom);
            default: program_regs($urandom_range(1000, 32000), $urandom_range(1, 600),
                                  $urandom, $urandom_range(0, 65535),
                                  $urandom_range(0, 63), $urandom_range(0, 7), 0);
         endcase
         calm = (ph == 4);
         if (ph == 2) hold_ask = 1;
         for (int n = 0; n < 300; n++) send_sample(rand_sample());
         wait_drained();
         calm = 0;
      end

      repeat (45) @(posedge clock);
      if (sb.errors == 0)
         $display("accel_motion_conditioner verification clean");
      else
         $display("accel_motion_conditioner verification failed");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("accel_motion_conditioner verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/amc_pkg.sv
sv/amc_ctrl.sv
sv/amc_datapath.sv
sv/accel_motion_conditioner.sv
tb/tb_accel_motion_conditioner.sv
